// ----- sv/longest_first_task_balancer_core_macros.svh -----
// ----------------------------------------------------------------------------
// longest first task balancer assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef LONGEST_FIRST_TASK_BALANCER_CORE_MACROS_SVH
`define LONGEST_FIRST_TASK_BALANCER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LFTB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lftb assertion failed");

// next-cycle implication
`define LFTB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lftb assertion failed");

`else

`define LFTB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LFTB_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/lftb_pkg.sv -----
// ----------------------------------------------------------------------------
// lftb_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lftb_pkg;

    localparam int SERVERS     = 3;
    localparam int SRV_W       = $clog2(SERVERS);
    localparam int SERVER_FW   = 2;
    localparam int BATCH_DEPTH = 32;
    localparam int CNT_W       = $clog2(BATCH_DEPTH + 1);
    localparam int DUR_W       = 4;
    localparam int LOAD_W      = 32;
    localparam int MIN_DUR     = 1;
    localparam int MAX_DUR     = 9;
    localparam int BIN_IDX_W   = $clog2(MAX_DUR);

    typedef struct packed {
        logic accept;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic last_one;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ----- sv/lftb_ctrl.sv -----
// ----------------------------------------------------------------------------
// lftb_ctrl
// sequences the load and emission phases of a batch
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lftb_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic            i_last,
    input  wire lftb_pkg::t_status i_status,
    output lftb_pkg::t_cmd       o_cmd,
    output logic                 o_stall
);
    import lftb_pkg::*;

    typedef enum logic {
        S_LOAD,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd.accept = (r_state == S_LOAD) && i_valid;
        o_cmd.emit   = (r_state == S_EMIT) && i_status.out_free;
        n_state      = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_valid && i_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // a rejected batch gives one result, otherwise stop on the final task
                if (i_status.out_free && (i_status.bad || i_status.last_one)) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_LOAD);

endmodule

`default_nettype wire

// ----- sv/lftb_dp.sv -----
// ----------------------------------------------------------------------------
// lftb_dp
// duration bins, server loads and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lftb_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire lftb_pkg::t_cmd               i_cmd,
    input  wire logic [lftb_pkg::DUR_W-1:0]   i_duration,
    input  wire logic                         i_stall,
    output lftb_pkg::t_status                 o_status,
    output logic                              o_valid,
    output logic [lftb_pkg::SERVER_FW-1:0]    o_server,
    output logic [lftb_pkg::DUR_W-1:0]        o_task_duration,
    output logic [lftb_pkg::LOAD_W-1:0]       o_server_load_after,
    output logic                              o_invalid,
    output logic                              o_final_res
);
    import lftb_pkg::*;

    logic [CNT_W-1:0]  r_bins [MAX_DUR];
    logic [LOAD_W-1:0] r_load [SERVERS];
    logic              r_bad;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;

    logic [SRV_W-1:0]     best;
    logic [BIN_IDX_W-1:0] sel_bin;
    logic [DUR_W-1:0]     sel_dur;
    logic [LOAD_W:0]      sum;
    logic [LOAD_W-1:0]    n_load;
    logic                 dur_ok;
    logic [BIN_IDX_W-1:0] in_bin;

    always_comb begin
        best = '0;
        for (int s = 1; s < SERVERS; s++) begin
            if (r_load[s] < r_load[best]) begin
                best = SRV_W'(s);
            end
        end
        // highest non-empty bin wins
        sel_bin = '0;
        for (int d = 0; d < MAX_DUR; d++) begin
            if (r_bins[d] != '0) begin
                sel_bin = BIN_IDX_W'(d);
            end
        end
        sel_dur = DUR_W'(sel_bin) + DUR_W'(MIN_DUR);
        sum     = {1'b0, r_load[best]} + (LOAD_W + 1)'(sel_dur);
        n_load  = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
        dur_ok  = (i_duration >= DUR_W'(MIN_DUR)) && (i_duration <= DUR_W'(MAX_DUR));
        in_bin  = BIN_IDX_W'(i_duration - DUR_W'(MIN_DUR));
    end

    assign o_status.bad      = r_bad;
    assign o_status.last_one = (r_count == CNT_W'(1));
    assign o_status.out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DUR; d++) begin
                r_bins[d] <= '0;
            end
            for (int s = 0; s < SERVERS; s++) begin
                r_load[s] <= '0;
            end
            r_bad       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (!dur_ok || r_count >= CNT_W'(BATCH_DEPTH)) begin
                    r_bad <= 1'b1;
                end else begin
                    r_bins[in_bin] <= r_bins[in_bin] + CNT_W'(1);
                    r_count        <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.emit) begin
                if (r_bad) begin
                    for (int d = 0; d < MAX_DUR; d++) begin
                        r_bins[d] <= '0;
                    end
                    r_bad   <= 1'b0;
                    r_count <= '0;
                end else begin
                    r_bins[sel_bin] <= r_bins[sel_bin] - CNT_W'(1);
                    r_count         <= r_count - CNT_W'(1);
                    r_load[best]    <= n_load;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_bad) begin
                o_server            <= '0;
                o_task_duration     <= '0;
                o_server_load_after <= '0;
                o_invalid           <= 1'b1;
                o_final_res         <= 1'b1;
            end else begin
                o_server            <= SERVER_FW'(best);
                o_task_duration     <= sel_dur;
                o_server_load_after <= n_load;
                o_invalid           <= 1'b0;
                o_final_res         <= (r_count == CNT_W'(1));
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- sv/longest_first_task_balancer_core.sv -----
// ----------------------------------------------------------------------------
// longest_first_task_balancer_core
// longest-first assignment of task batches to the least loaded server
// ----------------------------------------------------------------------------
// Task durations enter one request per cycle and are counted into nine bins;
// the request marked last closes the batch. The block then stalls its input
// and, while the output is not stalled, emits one assignment per cycle,
// longest task first, each to the server with the smallest running load
// (lowest index on ties). A batch of N tasks gives N results, and a rejected
// batch (duration outside 1..9 or more than 32 tasks) gives a single invalid
// result; output stalls stretch the emission phase. The per-cycle limit is
// the three-way load compare feeding the saturating add. Server loads are
// kept across batches and saturate at all ones.
`timescale 1ns / 1ps
`default_nettype none

`include "longest_first_task_balancer_core_macros.svh"

module longest_first_task_balancer_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [lftb_pkg::DUR_W-1:0]   i_duration,
    input  wire logic                         i_last,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [lftb_pkg::SERVER_FW-1:0]    o_server,
    output logic [lftb_pkg::DUR_W-1:0]        o_task_duration,
    output logic [lftb_pkg::LOAD_W-1:0]       o_server_load_after,
    output logic                              o_invalid,
    output logic                              o_final_res
);
    import lftb_pkg::*;

    t_cmd    cmd;
    t_status status;

    lftb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_last   (i_last),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    lftb_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_duration          (i_duration),
        .i_stall             (i_stall),
        .o_status            (status),
        .o_valid             (o_valid),
        .o_server            (o_server),
        .o_task_duration     (o_task_duration),
        .o_server_load_after (o_server_load_after),
        .o_invalid           (o_invalid),
        .o_final_res         (o_final_res)
    );

    // a rejected batch always closes with its single result
    `LFTB_ASSERT_IMP(a_invalid_is_final, i_clk, i_rst_n, o_valid && o_invalid, o_final_res)
    // closing a batch stops the input until its last result is registered
    `LFTB_ASSERT_NXT(a_last_stalls, i_clk, i_rst_n, i_valid && !o_stall && i_last, o_stall)
    // results of one batch follow back to back once the previous one is taken
    `LFTB_ASSERT_NXT(a_emit_continues, i_clk, i_rst_n,
        o_valid && !o_final_res && !i_stall, o_valid)

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench for longest_first_task_balancer_core
// drives batches of task durations, predicts each longest-first assignment
// and its running server load, and checks every result field on the output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import lftb_pkg::*;

    typedef struct packed {
        logic [SERVER_FW-1:0] server;
        logic [DUR_W-1:0]     task_duration;
        logic [LOAD_W-1:0]    load_after;
        logic                 invalid;
        logic                 final_res;
    } t_assignment;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [DUR_W-1:0]     i_duration;
    logic                 i_last;
    logic                 o_valid;
    logic                 i_stall;
    logic [SERVER_FW-1:0] o_server;
    logic [DUR_W-1:0]     o_task_duration;
    logic [LOAD_W-1:0]    o_server_load_after;
    logic                 o_invalid;
    logic                 o_final_res;

    // predictor state
    int                   dur_bins [MIN_DUR:MAX_DUR];
    logic [LOAD_W-1:0]    srv_load [SERVERS];
    logic                 batch_rejected;
    int                   batch_tasks;
    t_assignment          assignment_q [$];
    t_assignment          want;

    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   hold_left;
    int                   errors;
    int                   requests_sent;
    int                   batches_sent;
    int                   results_checked;
    int                   rejects_checked;

    longest_first_task_balancer_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_duration          (i_duration),
        .i_last              (i_last),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_server            (o_server),
        .o_task_duration     (o_task_duration),
        .o_server_load_after (o_server_load_after),
        .o_invalid           (o_invalid),
        .o_final_res         (o_final_res)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // bin one request; on the last one of a batch, queue its assignments
    task automatic predict_request(input logic [DUR_W-1:0] dur, input logic lst);
        t_assignment       a;
        int                best;
        int                left;
        logic [LOAD_W:0]   sum;
        if (dur < MIN_DUR || dur > MAX_DUR) begin
            batch_rejected = 1'b1;
        end else if (batch_tasks >= BATCH_DEPTH) begin
            batch_rejected = 1'b1;
        end else begin
            dur_bins[dur]++;
            batch_tasks++;
        end
        if (lst) begin
            batches_sent++;
            if (batch_rejected) begin
                a = '0;
                a.invalid = 1'b1;
                a.final_res = 1'b1;
                assignment_q = {assignment_q, a};
            end else begin
                left = batch_tasks;
                for (int d = MAX_DUR; d >= MIN_DUR; d--) begin
                    while (dur_bins[d] > 0) begin
                        best = 0;
                        for (int s = 1; s < SERVERS; s++) begin
                            if (srv_load[s] < srv_load[best]) best = s;
                        end
                        sum = {1'b0, srv_load[best]} + (LOAD_W + 1)'(d);
                        srv_load[best] = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
                        dur_bins[d]--;
                        left--;
                        a.server = SERVER_FW'(best);
                        a.task_duration = DUR_W'(d);
                        a.load_after = srv_load[best];
                        a.invalid = 1'b0;
                        a.final_res = (left == 0);
                        assignment_q = {assignment_q, a};
                    end
                end
            end
            for (int d = MIN_DUR; d <= MAX_DUR; d++) dur_bins[d] = 0;
            batch_rejected = 1'b0;
            batch_tasks = 0;
        end
    endtask

    // offer one request, hold it until taken, then maybe go idle
    task automatic send_request(input logic [DUR_W-1:0] dur, input logic lst);
        int gap;
        i_valid <= 1'b1;
        i_duration <= dur;
        i_last <= lst;
        do @(posedge i_clk); while (o_stall);
        requests_sent++;
        predict_request(dur, lst);
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic end_phase();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (assignment_q.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [LOAD_W-1:0] exp_val,
                               input logic [LOAD_W-1:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (assignment_q.size() == 0) begin
                $error("result with nothing pending: server %0d duration %0d invalid %0b",
                       o_server, o_task_duration, o_invalid);
                errors++;
            end else begin
                want = assignment_q.pop_front();
                check_field("server", want.server, o_server);
                check_field("task_duration", want.task_duration, o_task_duration);
                check_field("server_load_after", want.load_after, o_server_load_after);
                check_field("invalid", want.invalid, o_invalid);
                check_field("final_res", want.final_res, o_final_res);
                results_checked++;
                if (want.invalid) rejects_checked++;
            end
        end
    end

    // receiver side, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic [DUR_W-1:0] good_duration();
        return DUR_W'($urandom_range(MAX_DUR, MIN_DUR));
    endfunction

    function automatic logic [DUR_W-1:0] bad_duration();
        logic [DUR_W-1:0] d;
        d = DUR_W'($urandom_range(6));
        return (d == 0) ? d : d + DUR_W'(MAX_DUR);
    endfunction

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_request(4'd1, 1'b1);
        // ties between servers and the longest duration
        send_request(4'd9, 1'b0);
        send_request(4'd2, 1'b0);
        send_request(4'd9, 1'b0);
        send_request(4'd5, 1'b1);
        send_request(4'd0, 1'b1);
        send_request(4'd15, 1'b1);
        // out-of-range duration in the middle of a batch
        send_request(4'd3, 1'b0);
        send_request(4'd10, 1'b0);
        send_request(4'd4, 1'b1);
        send_request(4'd7, 1'b0);
        send_request(4'd7, 1'b0);
        send_request(4'd7, 1'b1);
        // out-of-range duration on the closing request
        send_request(4'd6, 1'b0);
        send_request(4'd0, 1'b1);
        send_request(4'd8, 1'b0);
        send_request(4'd1, 1'b1);
        end_phase();
    endtask

    task automatic test_batch_depth();
        send_idle_pct = 34;
        recv_stall_pct = 34;
        for (int k = 0; k < BATCH_DEPTH; k++) send_request(good_duration(), k == BATCH_DEPTH - 1);
        // one request past the depth rejects the batch
        for (int k = 0; k <= BATCH_DEPTH; k++) send_request(good_duration(), k == BATCH_DEPTH);
        end_phase();
    endtask

    task automatic test_output_hold();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left <= 300;
        for (int b = 0; b < 3; b++) begin
            for (int k = 0; k < 6; k++) send_request(good_duration(), k == 5);
        end
        end_phase();
    endtask

    task automatic test_random_batches(input int n_requests, input int idle_pct,
                                       input int stall_pct);
        int sent;
        int size;
        int pick;
        int bad_pos;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_requests) begin
            pick = $urandom_range(99);
            if (pick < 80) size = $urandom_range(8, 1);
            else if (pick < 90) size = $urandom_range(BATCH_DEPTH - 1, 9);
            else if (pick < 95) size = BATCH_DEPTH;
            else size = BATCH_DEPTH + 1;
            bad_pos = ($urandom_range(9) == 0) ? $urandom_range(size - 1) : -1;
            for (int k = 0; k < size; k++) begin
                send_request((k == bad_pos) ? bad_duration() : good_duration(), k == size - 1);
            end
            sent += size;
        end
        end_phase();
    endtask

    initial begin
        for (int d = MIN_DUR; d <= MAX_DUR; d++) dur_bins[d] = 0;
        for (int s = 0; s < SERVERS; s++) srv_load[s] = '0;
        batch_rejected = 1'b0;
        batch_tasks = 0;
        errors = 0;
        requests_sent = 0;
        batches_sent = 0;
        results_checked = 0;
        rejects_checked = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_duration <= '0;
        i_last <= 1'b0;
        i_stall <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_batch_depth();
        test_output_hold();
        test_random_batches(20, 0, 0);
        test_random_batches(20, 79, 0);
        test_random_batches(20, 0, 79);
        test_random_batches(20, 34, 34);

        repeat (20) @(posedge i_clk);
        $display("covered %0d requests in %0d batches across idle and stall mixes",
                 requests_sent, batches_sent);
        $display("checked %0d results, %0d of them rejected batches",
                 results_checked, rejects_checked);
        if (errors == 0 && assignment_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (assignment_q.size() != 0) begin
                $error("%0d results never arrived", assignment_q.size());
            end
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/lftb_pkg.sv
sv/lftb_ctrl.sv
sv/lftb_dp.sv
sv/longest_first_task_balancer_core.sv
tb/testbench.sv
